@@ src/lzwe_pkg.sv @@
// lzwe_pkg: shared constants, types and helpers of the lzw variable width encoder
// used by lzwe_ctrl, lzwe_datapath and the top level; depends on nothing
package lzwe_pkg;

  localparam int MAX_CODE_WIDTH = 12;
  localparam int CODE_W   = MAX_CODE_WIDTH;
  localparam int NEXT_W   = CODE_W + 1;
  localparam int KEY_W    = CODE_W + 8;
  localparam int HASH_W   = CODE_W + 1;
  localparam int DICT_DEPTH = 1 << HASH_W;
  localparam int EPOCH_W  = 8;
  localparam int ENTRY_W  = EPOCH_W + KEY_W + CODE_W;
  localparam int BUF_W    = CODE_W + 7;
  localparam int CNT_W    = $clog2(BUF_W + 1);
  localparam int WIDTH_W  = $clog2(MAX_CODE_WIDTH + 1);
  localparam int STATE_W  = 4;

  localparam logic [CODE_W-1:0]  CODE_CLEAR  = CODE_W'(256);
  localparam logic [CODE_W-1:0]  CODE_END    = CODE_W'(257);
  localparam logic [NEXT_W-1:0]  CODE_FIRST  = NEXT_W'(258);
  localparam logic [NEXT_W-1:0]  CODE_TOP    = NEXT_W'((1 << CODE_W) - 1);
  localparam logic [WIDTH_W-1:0] WIDTH_START = WIDTH_W'(9);
  localparam logic [WIDTH_W-1:0] WIDTH_MAX   = WIDTH_W'(MAX_CODE_WIDTH);
  localparam logic [EPOCH_W-1:0] EPOCH_MAX   = {EPOCH_W{1'b1}};
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);

  typedef enum logic [1:0] {
    SEL_PREFIX,
    SEL_CLEAR,
    SEL_END
  } code_sel_e;

  typedef struct packed {
    logic      latch_in;
    logic      emit;
    code_sel_e sel;
    logic      set_final;
    logic      start_stream;
    logic      look;
    logic      probe_next;
    logic      prefix_hit;
    logic      prefix_byte;
    logic      insert;
    logic      clear_table;
    logic      grow_last;
    logic      end_stream;
    logic      sweep_init;
    logic      sweep_step;
  } cmd_t;

  typedef struct packed {
    logic started;
    logic last;
    logic buf_ready;
    logic hit;
    logic empty;
    logic full;
    logic need_sweep;
    logic sweep_done;
  } stat_t;

  // width grows when x is a power of two and the top width is not reached
  function automatic logic grow_ok(logic [WIDTH_W-1:0] w, logic [NEXT_W:0] x);
    grow_ok = (w < WIDTH_MAX) && (x != '0) && ((x & (x - 1'b1)) == '0);
  endfunction

  // fold a 20 bit key into a table slot
  function automatic logic [HASH_W-1:0] hash_key(logic [KEY_W-1:0] k);
    hash_key = k[HASH_W-1:0] ^ HASH_W'(k >> (KEY_W - HASH_W));
  endfunction

endpackage

@@ src/lzwe_ctrl.sv @@
// lzwe_ctrl: sequencer of the lzw encoder, one input item at a time
// depends on lzwe_pkg; drives lzwe_datapath through cmd_t and reads stat_t
module lzwe_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  lzwe_pkg::stat_t stat_i,
  output lzwe_pkg::cmd_t  cmd_o
);

  localparam logic [lzwe_pkg::STATE_W-1:0] S_SWEEP = 4'd0;
  localparam logic [lzwe_pkg::STATE_W-1:0] S_IDLE  = 4'd1;
  localparam logic [lzwe_pkg::STATE_W-1:0] S_START = 4'd2;
  localparam logic [lzwe_pkg::STATE_W-1:0] S_LOOK  = 4'd3;
  localparam logic [lzwe_pkg::STATE_W-1:0] S_WAIT  = 4'd4;
  localparam logic [lzwe_pkg::STATE_W-1:0] S_PROBE = 4'd5;
  localparam logic [lzwe_pkg::STATE_W-1:0] S_MEMIT = 4'd6;
  localparam logic [lzwe_pkg::STATE_W-1:0] S_INS   = 4'd7;
  localparam logic [lzwe_pkg::STATE_W-1:0] S_MCLR  = 4'd8;
  localparam logic [lzwe_pkg::STATE_W-1:0] S_LAST  = 4'd9;
  localparam logic [lzwe_pkg::STATE_W-1:0] S_LEMIT = 4'd10;
  localparam logic [lzwe_pkg::STATE_W-1:0] S_LGROW = 4'd11;
  localparam logic [lzwe_pkg::STATE_W-1:0] S_LEND  = 4'd12;
  localparam logic [lzwe_pkg::STATE_W-1:0] S_FIN   = 4'd13;

  logic [lzwe_pkg::STATE_W-1:0] state_q, state_d;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.sel  = lzwe_pkg::SEL_PREFIX;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_SWEEP: begin
        cmd_o.sweep_step = 1'b1;
        if (stat_i.sweep_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d = stat_i.started ? S_LOOK : S_START;
        end
      end
      S_START: begin
        if (stat_i.buf_ready) begin
          cmd_o.emit         = 1'b1;
          cmd_o.sel          = lzwe_pkg::SEL_CLEAR;
          cmd_o.start_stream = 1'b1;
          state_d = S_LAST;
        end
      end
      S_LOOK: begin
        cmd_o.look = 1'b1;
        state_d = S_WAIT;
      end
      S_WAIT: begin
        state_d = S_PROBE;
      end
      S_PROBE: begin
        if (stat_i.hit) begin
          cmd_o.prefix_hit = 1'b1;
          state_d = S_LAST;
        end else if (stat_i.empty) begin
          state_d = S_MEMIT;
        end else begin
          cmd_o.probe_next = 1'b1;
          state_d = S_WAIT;
        end
      end
      S_MEMIT: begin
        if (stat_i.buf_ready) begin
          cmd_o.emit = 1'b1;
          state_d = stat_i.full ? S_MCLR : S_INS;
        end
      end
      S_INS: begin
        cmd_o.insert      = 1'b1;
        cmd_o.prefix_byte = 1'b1;
        state_d = S_LAST;
      end
      S_MCLR: begin
        if (stat_i.buf_ready) begin
          cmd_o.emit        = 1'b1;
          cmd_o.sel         = lzwe_pkg::SEL_CLEAR;
          cmd_o.clear_table = 1'b1;
          cmd_o.prefix_byte = 1'b1;
          state_d = S_LAST;
        end
      end
      S_LAST: begin
        state_d = stat_i.last ? S_LEMIT : S_FIN;
      end
      S_LEMIT: begin
        if (stat_i.buf_ready) begin
          cmd_o.emit = 1'b1;
          state_d = S_LGROW;
        end
      end
      S_LGROW: begin
        cmd_o.grow_last = 1'b1;
        state_d = S_LEND;
      end
      S_LEND: begin
        if (stat_i.buf_ready) begin
          cmd_o.emit        = 1'b1;
          cmd_o.sel         = lzwe_pkg::SEL_END;
          cmd_o.set_final   = 1'b1;
          cmd_o.clear_table = 1'b1;
          cmd_o.end_stream  = 1'b1;
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (stat_i.need_sweep) begin
          cmd_o.sweep_init = 1'b1;
          state_d = S_SWEEP;
        end else begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state register, reset starts with the table sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_SWEEP;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ src/lzwe_datapath.sv @@
// lzwe_datapath: hashed dictionary memory, stream registers, bit packer, output register
// depends on lzwe_pkg; commanded by lzwe_ctrl
module lzwe_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  grow_early_we_i,
  input  logic                  grow_early_i,
  input  logic [7:0]            data_byte_i,
  input  logic                  is_last_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            packed_byte_o,
  output logic                  last_out_o,
  input  lzwe_pkg::cmd_t        cmd_i,
  output lzwe_pkg::stat_t       stat_o
);

  logic [lzwe_pkg::ENTRY_W-1:0] mem [lzwe_pkg::DICT_DEPTH];
  logic [lzwe_pkg::ENTRY_W-1:0] rd_q;

  logic                           ec_q;
  logic [7:0]                     byte_q;
  logic                           last_q;
  logic                           started_q;
  logic [lzwe_pkg::CODE_W-1:0]    prefix_q;
  logic [lzwe_pkg::NEXT_W-1:0]    next_q;
  logic [lzwe_pkg::WIDTH_W-1:0]   width_q;
  logic [lzwe_pkg::EPOCH_W-1:0]   epoch_q;
  logic                           need_sweep_q;
  logic [lzwe_pkg::HASH_W-1:0]    addr_q;
  logic [lzwe_pkg::BUF_W-1:0]     bits_q;
  logic [lzwe_pkg::CNT_W-1:0]     cnt_q;
  logic                           final_q;
  logic                           ov_q;
  logic [7:0]                     ob_q;
  logic                           ol_q;

  logic [lzwe_pkg::KEY_W-1:0]     key_cur;
  logic [lzwe_pkg::EPOCH_W-1:0]   rd_epoch;
  logic [lzwe_pkg::KEY_W-1:0]     rd_key;
  logic [lzwe_pkg::CODE_W-1:0]    rd_code;
  logic [lzwe_pkg::CODE_W-1:0]    code;
  logic                           out_load;
  logic                           drain;
  logic                           pad;
  logic [lzwe_pkg::BUF_W-1:0]     drain_bits;
  logic [lzwe_pkg::BUF_W-1:0]     pad_bits;
  logic                           mem_we;
  logic [lzwe_pkg::ENTRY_W-1:0]   mem_wdata;

  assign key_cur = {prefix_q, byte_q};
  assign {rd_epoch, rd_key, rd_code} = rd_q;

  // status toward the sequencer
  assign stat_o.started    = started_q;
  assign stat_o.last       = last_q;
  assign stat_o.buf_ready  = (cnt_q < lzwe_pkg::CNT_W'(8)) && !final_q;
  assign stat_o.hit        = (rd_epoch == epoch_q) && (rd_key == key_cur);
  assign stat_o.empty      = (rd_epoch != epoch_q);
  assign stat_o.full       = (next_q > lzwe_pkg::CODE_TOP);
  assign stat_o.need_sweep = need_sweep_q;
  assign stat_o.sweep_done = (addr_q == {lzwe_pkg::HASH_W{1'b1}});

  // code to append
  always_comb begin
    case (cmd_i.sel)
      lzwe_pkg::SEL_CLEAR: code = lzwe_pkg::CODE_CLEAR;
      lzwe_pkg::SEL_END:   code = lzwe_pkg::CODE_END;
      default:             code = prefix_q;
    endcase
  end

  // output byte selection
  assign out_load   = !ov_q || out_ready_i;
  assign drain      = out_load && (cnt_q >= lzwe_pkg::CNT_W'(8));
  assign pad        = out_load && final_q && (cnt_q != '0) && (cnt_q < lzwe_pkg::CNT_W'(8));
  assign drain_bits = bits_q >> (cnt_q - lzwe_pkg::CNT_W'(8));
  assign pad_bits   = bits_q << (lzwe_pkg::CNT_W'(8) - cnt_q);

  // dictionary write port
  assign mem_we    = cmd_i.insert || cmd_i.sweep_step;
  assign mem_wdata = cmd_i.insert ? {epoch_q, key_cur, next_q[lzwe_pkg::CODE_W-1:0]} : '0;

  // dictionary memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[addr_q] <= mem_wdata;
    end
    rd_q <= mem[addr_q];
  end

  // latched input item
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      byte_q <= data_byte_i;
      last_q <= is_last_i;
    end
  end

  // stream and dictionary state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ec_q         <= 1'b1;
      started_q    <= 1'b0;
      prefix_q     <= '0;
      next_q       <= lzwe_pkg::CODE_FIRST;
      width_q      <= lzwe_pkg::WIDTH_START;
      epoch_q      <= lzwe_pkg::EPOCH_FIRST;
      need_sweep_q <= 1'b0;
      addr_q       <= '0;
    end else begin
      if (grow_early_we_i) ec_q <= grow_early_i;
      if (cmd_i.start_stream) begin
        prefix_q  <= {{(lzwe_pkg::CODE_W-8){1'b0}}, byte_q};
        started_q <= 1'b1;
      end
      if (cmd_i.prefix_hit) prefix_q <= rd_code;
      if (cmd_i.prefix_byte) prefix_q <= {{(lzwe_pkg::CODE_W-8){1'b0}}, byte_q};
      if (cmd_i.look) addr_q <= lzwe_pkg::hash_key(key_cur);
      if (cmd_i.probe_next) addr_q <= addr_q + 1'b1;
      if (cmd_i.sweep_init) addr_q <= '0;
      if (cmd_i.sweep_step) begin
        addr_q <= addr_q + 1'b1;
        if (stat_o.sweep_done) need_sweep_q <= 1'b0;
      end
      if (cmd_i.insert) begin
        next_q <= next_q + 1'b1;
        if (lzwe_pkg::grow_ok(width_q, {1'b0, next_q} + {{lzwe_pkg::NEXT_W{1'b0}}, ec_q}))
          width_q <= width_q + 1'b1;
      end
      if (cmd_i.grow_last) begin
        if (lzwe_pkg::grow_ok(width_q, {1'b0, next_q} + {{lzwe_pkg::NEXT_W{1'b0}}, ec_q}))
          width_q <= width_q + 1'b1;
      end
      // table clear moves to a fresh epoch, a wrap asks for a sweep
      if (cmd_i.clear_table) begin
        next_q  <= lzwe_pkg::CODE_FIRST;
        width_q <= lzwe_pkg::WIDTH_START;
        if (epoch_q == lzwe_pkg::EPOCH_MAX) begin
          epoch_q      <= lzwe_pkg::EPOCH_FIRST;
          need_sweep_q <= 1'b1;
        end else begin
          epoch_q <= epoch_q + 1'b1;
        end
      end
      if (cmd_i.end_stream) begin
        started_q <= 1'b0;
        prefix_q  <= '0;
      end
    end
  end

  // bit packer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_q  <= '0;
      cnt_q   <= '0;
      final_q <= 1'b0;
      ov_q    <= 1'b0;
      ob_q    <= '0;
      ol_q    <= 1'b0;
    end else begin
      if (ov_q && out_ready_i) ov_q <= 1'b0;
      if (cmd_i.emit) begin
        bits_q <= (bits_q << width_q) | lzwe_pkg::BUF_W'(code);
        cnt_q  <= cnt_q + lzwe_pkg::CNT_W'(width_q);
      end
      if (cmd_i.set_final) final_q <= 1'b1;
      if (drain) begin
        ov_q  <= 1'b1;
        ob_q  <= drain_bits[7:0];
        ol_q  <= final_q && (cnt_q == lzwe_pkg::CNT_W'(8));
        cnt_q <= cnt_q - lzwe_pkg::CNT_W'(8);
        if (final_q && (cnt_q == lzwe_pkg::CNT_W'(8))) final_q <= 1'b0;
      end else if (pad) begin
        ov_q    <= 1'b1;
        ob_q    <= pad_bits[7:0];
        ol_q    <= 1'b1;
        cnt_q   <= '0;
        bits_q  <= '0;
        final_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = ov_q;
  assign packed_byte_o = ob_q;
  assign last_out_o    = ol_q;

endmodule

@@ src/lzw_variable_width_encoder.sv @@
// lzw_variable_width_encoder: top level of the lzw encoder with 9 to 12 bit codes
// depends on lzwe_pkg, lzwe_ctrl and lzwe_datapath
//
// Takes raw bytes and gives LZW codes packed MSB-first into bytes, one input
// byte at a time. The first byte of a stream emits the clear code before the
// next byte can be taken. A byte that extends the current string is looked up
// in the hashed dictionary (8192 slots, linear probing, one read port with
// registered data); a byte that ends a string adds an emit and an insert (or
// an emit of the clear code when the table is full), and the last byte of a
// stream adds an emit of the last code and of the end code. Packed bytes
// leave through an output register at one per cycle while the receiver is
// ready, and an emit waits until fewer than 8 bits are pending and the final
// bits of the previous stream have left. After reset, and after every 255th
// dictionary clear, a clearing pass over all 8192 slots runs during which no
// byte is taken; grow_early may be written at any time outside a stream.
module lzw_variable_width_encoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       grow_early_we_i,
  input  logic       grow_early_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       is_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] packed_byte_o,
  output logic       last_out_o
);

  lzwe_pkg::cmd_t  cmd;
  lzwe_pkg::stat_t stat;

  // sequencer
  lzwe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // dictionary and packer
  lzwe_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .grow_early_we_i (grow_early_we_i),
    .grow_early_i    (grow_early_i),
    .data_byte_i     (data_byte_i),
    .is_last_i       (is_last_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .packed_byte_o   (packed_byte_o),
    .last_out_o      (last_out_o),
    .cmd_i           (cmd),
    .stat_o          (stat)
  );

endmodule

@@ src/lzwe_checker.sv @@
// lzwe_checker: port level assertions of the lzw encoder
// bound to lzw_variable_width_encoder; depends on no package
module lzwe_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] packed_byte_o,
  input logic       last_out_o
);

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output valid dropped before transfer");

  // one byte at a time: no input transfer right after another
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while previous byte in work");

  // a stalled result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(packed_byte_o) && $stable(last_out_o))
    else $error("output payload changed before transfer");

endmodule

bind lzw_variable_width_encoder lzwe_checker u_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .packed_byte_o (packed_byte_o),
  .last_out_o    (last_out_o)
);

@@ test/tb.sv @@
// tb: self-checking testbench of lzw_variable_width_encoder
// depends on the encoder rtl; predicts the packed code stream byte by byte and checks each transfer
module tb;

  typedef struct {
    logic [7:0] pbyte;
    logic       plast;
  } packed_out_t;

  localparam int CODE_CLEAR_V = 256;
  localparam int CODE_END_V   = 257;
  localparam int CODE_FIRST_V = 258;
  localparam int CODE_TOP_V   = 4095;
  localparam int WIDTH_START_V = 9;
  localparam int WIDTH_MAX_V  = 12;
  localparam int CYCLE_LIMIT  = 1500000;
  localparam int SETTLE       = 40;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       grow_early_we_i = 1'b0;
  logic       grow_early_i = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] data_byte_i = 8'h00;
  logic       is_last_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] packed_byte_o;
  logic       last_out_o;

  lzw_variable_width_encoder u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .grow_early_we_i(grow_early_we_i),
    .grow_early_i   (grow_early_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .is_last_i      (is_last_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .packed_byte_o  (packed_byte_o),
    .last_out_o     (last_out_o)
  );

  // clock
  always #5 clk_i = ~clk_i;

  // encoder shadow state
  int          code_of_key[int];
  int          cur_prefix;
  int          free_code;
  int          cur_width;
  logic [7:0]  bit_acc;
  int          bit_cnt;
  bit          in_stream;
  bit          grow_early;

  packed_out_t expected_bytes[$];
  int          n_pushed;
  int          mismatches;
  int          cycles;
  int          hold_cycles;
  bit          no_idle;

  // append one code msb first to the pending bits
  task automatic pack_code(input int code);
    packed_out_t e;
    for (int i = cur_width - 1; i >= 0; i--) begin
      bit_acc = {bit_acc[6:0], 1'(code >> i)};
      bit_cnt++;
      if (bit_cnt == 8) begin
        e.pbyte = bit_acc;
        e.plast = 1'b0;
        expected_bytes.insert(expected_bytes.size(), e);
        n_pushed++;
        bit_acc = '0;
        bit_cnt = 0;
      end
    end
  endtask

  task automatic widen_if_pow2(input int x);
    if (cur_width < WIDTH_MAX_V && x != 0 && (x & (x - 1)) == 0) cur_width++;
  endtask

  task automatic wipe_table();
    code_of_key.delete();
    free_code = CODE_FIRST_V;
    cur_width = WIDTH_START_V;
  endtask

  // work out the packed bytes caused by one accepted input byte
  task automatic encode_byte(input logic [7:0] b, input logic lst);
    packed_out_t e;
    int key;
    n_pushed = 0;
    if (!in_stream) begin
      pack_code(CODE_CLEAR_V);
      cur_prefix = b;
      in_stream = 1'b1;
    end else begin
      key = (cur_prefix << 8) | b;
      if (code_of_key.exists(key)) begin
        cur_prefix = code_of_key[key];
      end else begin
        pack_code(cur_prefix);
        if (free_code <= CODE_TOP_V) begin
          code_of_key[key] = free_code;
          free_code++;
          widen_if_pow2(free_code + grow_early - 1);
        end else begin
          pack_code(CODE_CLEAR_V);
          wipe_table();
        end
        cur_prefix = b;
      end
    end
    if (lst) begin
      pack_code(cur_prefix);
      widen_if_pow2(free_code + grow_early);
      pack_code(CODE_END_V);
      if (bit_cnt > 0) begin
        e.pbyte = bit_acc << (8 - bit_cnt);
        e.plast = 1'b0;
        expected_bytes.insert(expected_bytes.size(), e);
        n_pushed++;
        bit_acc = '0;
        bit_cnt = 0;
      end
      if (n_pushed > 0) expected_bytes[$].plast = 1'b1;
      wipe_table();
      cur_prefix = 0;
      in_stream = 1'b0;
    end
  endtask

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  // offer one byte and hold it until the transfer
  task automatic send_byte(input logic [7:0] b, input logic lst);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    is_last_i   <= lst;
    do @(posedge clk_i); while (!in_ready_o);
    encode_byte(b, lst);
  endtask

  // lower valid and wait for every expected byte plus the tail latency
  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_bytes.size() > 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_grow_early(input logic v);
    drain();
    grow_early_we_i <= 1'b1;
    grow_early_i    <= v;
    @(posedge clk_i);
    grow_early_we_i <= 1'b0;
    grow_early = v;
  endtask

  // random stream; small alphabets give dictionary hits
  task automatic send_stream(input int len, input int alpha);
    for (int i = 0; i < len; i++)
      send_byte(8'($urandom_range(0, alpha)), i == len - 1);
  endtask

  task automatic test_directed();
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b1);
    send_byte(8'h41, 1'b0);
    send_byte(8'h42, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'h42, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'h42, 1'b0);
    send_byte(8'h41, 1'b1);
    for (int i = 0; i < 8; i++) send_byte(8'hff, i == 7);
    send_byte(8'h00, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'haa, 1'b1);
  endtask

  task automatic test_grow_early();
    write_grow_early(1'b0);
    send_byte(8'h00, 1'b1);
    send_stream(12, 3);
    send_stream(12, 255);
    write_grow_early(1'b1);
    send_stream(10, 3);
  endtask

  task automatic test_random();
    int sent;
    sent = 0;
    while (sent < 50) begin
      int len;
      len = $urandom_range(1, 30);
      if ($urandom_range(0, 3) == 0) begin
        no_idle = 1'b1;
      end
      send_stream(len, ($urandom_range(0, 1) != 0) ? 255 : $urandom_range(1, 7));
      no_idle = 1'b0;
      sent += len;
      if ($urandom_range(0, 9) == 0) write_grow_early(1'(($urandom_range(0, 1))));
    end
  endtask

  // receiver stalls long while bytes keep coming, then sender waits for all
  task automatic test_backpressure();
    hold_cycles = 400;
    send_stream(30, 255);
    in_valid_i <= 1'b0;
    while (expected_bytes.size() > 0) @(posedge clk_i);
    send_stream(10, 3);
  endtask

  // receiver ready, with long holds on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        out_ready_i <= 1'b0;
        hold_cycles--;
      end else begin
        out_ready_i <= no_idle || (pick_gap() == 0);
      end
    end
  end

  // compare every output transfer with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output byte %02h last %0b", packed_byte_o, last_out_o);
      end else begin
        packed_out_t e;
        e = expected_bytes.pop_front();
        if (e.pbyte !== packed_byte_o || e.plast !== last_out_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                     e.pbyte, e.plast, packed_byte_o, last_out_o);
        end
      end
    end
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    cycles = 0;
    mismatches = 0;
    hold_cycles = 0;
    no_idle = 1'b0;
    grow_early = 1'b1;
    bit_acc = '0;
    bit_cnt = 0;
    in_stream = 1'b0;
    cur_prefix = 0;
    wipe_table();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_grow_early();
    test_random();
    test_backpressure();
    drain();
    if (mismatches == 0 && expected_bytes.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/lzwe_pkg.sv
src/lzwe_ctrl.sv
src/lzwe_datapath.sv
src/lzw_variable_width_encoder.sv
src/lzwe_checker.sv
test/tb.sv
